@@ rtl/hpg_pkg.sv @@
// constants, register codes and lane helpers for the halton point generator
`timescale 1ns / 1ps

package hpg_pkg;

  // index and base setup
  localparam int unsigned INDEX_BITS = 20;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned BASE_X     = 2;
  localparam int unsigned BASE_Y     = 3;
  localparam int unsigned BASE_Z     = 5;
  localparam int unsigned BASE_XY    = (BASE_X > BASE_Y) ? BASE_X : BASE_Y;
  localparam int unsigned BASE_MAX   = (BASE_XY > BASE_Z) ? BASE_XY : BASE_Z;

  // datapath widths
  localparam int unsigned P_W     = INDEX_BITS + 1;            // sequence position
  localparam int unsigned DEN_W   = P_W + $clog2(BASE_MAX);    // base power and reversed digits
  localparam int unsigned FRAC_W  = 32;                        // q0.32 fraction
  localparam int unsigned COORD_W = 32;                        // q16.16 coordinate
  localparam int unsigned ACC_W   = COORD_W + FRAC_W;          // span times fraction

  // sequencing
  localparam int unsigned DIGIT_CYCLES = INDEX_BITS + 2;
  localparam int unsigned DIV_CYCLES   = FRAC_W + 1;
  localparam int unsigned CNT_W        = $clog2(DIV_CYCLES);

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [COORD_W-1:0] LOWER_RESET = 32'sh0000_0000;
  localparam logic [COORD_W-1:0] UPPER_RESET = 32'sh0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_X = 3'd0,
    REG_UPPER_X = 3'd1,
    REG_LOWER_Y = 3'd2,
    REG_UPPER_Y = 3'd3,
    REG_LOWER_Z = 3'd4,
    REG_UPPER_Z = 3'd5
  } cfg_reg_e;

  // base of each axis lane
  function automatic int unsigned axis_base(int unsigned axis);
    int unsigned b;
    case (axis)
      0:       b = BASE_X;
      1:       b = BASE_Y;
      default: b = BASE_Z;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/halton_point_generator.sv @@
// 3-d halton point generator: digit-serial radical inverse and bit-serial scaling
`timescale 1ns / 1ps

//  channel  | ports                                   | dir | notes
//  ---------+-----------------------------------------+-----+----------------------------
//  command  | start, busy, sample_index_i             | in  | word taken on start && !busy
//  result   | done_o, coord_x_o, coord_y_o, coord_z_o | out | one-cycle strobe, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i         | in  | write while idle only
//
// An accepted word runs through the digit steps (one base digit per cycle in each lane),
// then the steps of the bit-serial divide fused with the shift-add multiply, and one
// final add whose registered sum is the shown result.
// All three axes run side by side; the next word may be started on the edge
// that takes the result. Reset clears the bounds to the unit interval and idles.
// The receiver cannot stall; the result is shown for exactly one cycle.

module halton_point_generator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [hpg_pkg::INDEX_BITS-1:0]        sample_index_i,
  output logic                                  done_o,
  output logic [hpg_pkg::COORD_W-1:0]           coord_x_o,
  output logic [hpg_pkg::COORD_W-1:0]           coord_y_o,
  output logic [hpg_pkg::COORD_W-1:0]           coord_z_o,
  input  logic                                  cfg_we_i,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [hpg_pkg::COORD_W-1:0]           cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                        state_q;
  logic [hpg_pkg::CNT_W-1:0]     cnt_q;
  logic                          dv_q;
  logic                          done_q;
  logic                          accept;

  // interval bounds per axis
  logic [hpg_pkg::COORD_W-1:0]   cfg_lo_q [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::COORD_W-1:0]   cfg_hi_q [hpg_pkg::NUM_AXES];

  // lane datapath registers
  logic [hpg_pkg::P_W-1:0]       p_q     [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::P_W-1:0]       pprev_q [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::DEN_W-1:0]     rev_q   [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::DEN_W-1:0]     den_q   [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::DEN_W-1:0]     rem_q   [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::COORD_W:0]     diff_q  [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::COORD_W-1:0]   mag_q   [hpg_pkg::NUM_AXES];
  logic                          neg_q   [hpg_pkg::NUM_AXES];
  logic                          qb_q    [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::ACC_W-1:0]     acc_q   [hpg_pkg::NUM_AXES];
  logic [hpg_pkg::COORD_W-1:0]   coord_q [hpg_pkg::NUM_AXES];

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign coord_x_o = coord_q[0];
  assign coord_y_o = coord_q[1];
  assign coord_z_o = coord_q[2];

  // configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpg_pkg::NUM_AXES; i++) begin
        cfg_lo_q[i] <= hpg_pkg::LOWER_RESET;
        cfg_hi_q[i] <= hpg_pkg::UPPER_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hpg_pkg::REG_LOWER_X: cfg_lo_q[0] <= cfg_data_i;
        hpg_pkg::REG_UPPER_X: cfg_hi_q[0] <= cfg_data_i;
        hpg_pkg::REG_LOWER_Y: cfg_lo_q[1] <= cfg_data_i;
        hpg_pkg::REG_UPPER_Y: cfg_hi_q[1] <= cfg_data_i;
        hpg_pkg::REG_LOWER_Z: cfg_lo_q[2] <= cfg_data_i;
        hpg_pkg::REG_UPPER_Z: cfg_hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_DIGIT;
            cnt_q   <= '0;
            dv_q    <= 1'b0;
          end
        end
        ST_DIGIT: begin
          dv_q <= 1'b1;
          if (cnt_q == hpg_pkg::CNT_W'(hpg_pkg::DIGIT_CYCLES - 1)) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == hpg_pkg::CNT_W'(hpg_pkg::DIV_CYCLES - 1)) begin
            state_q <= ST_FIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // one lane per axis
  for (genvar a = 0; a < hpg_pkg::NUM_AXES; a++) begin : g_lane
    localparam int unsigned Base  = hpg_pkg::axis_base(a);
    localparam int unsigned Shift = hpg_pkg::P_W + $clog2(Base);
    localparam int unsigned ProdW = Shift + hpg_pkg::P_W;
    localparam longint unsigned Recip = ((64'd1 << Shift) + Base - 1) / Base;

    logic [ProdW-1:0]              prod;
    logic [hpg_pkg::P_W-1:0]       quot;
    logic [hpg_pkg::P_W-1:0]       dig;
    logic [hpg_pkg::DEN_W-1:0]     rev_step;
    logic [hpg_pkg::DEN_W:0]       rem2;
    logic                          rem_ge;
    logic [hpg_pkg::COORD_W:0]     diff;
    logic [hpg_pkg::ACC_W-1:0]     acc_add;
    logic [hpg_pkg::COORD_W-1:0]   acc_hi;
    logic                          sticky;

    // quotient by reciprocal multiply, exact over the position range
    assign prod = ProdW'(p_q[a]) * ProdW'(Recip);
    assign quot = prod[Shift +: hpg_pkg::P_W];
    // p_q holds the quotient of pprev_q, so this is the next digit
    assign dig  = pprev_q[a] - hpg_pkg::P_W'(p_q[a] * hpg_pkg::P_W'(Base));
    // reversed digits with the next digit appended
    assign rev_step = hpg_pkg::DEN_W'(rev_q[a] * hpg_pkg::DEN_W'(Base))
                    + hpg_pkg::DEN_W'(dig);

    // restoring divide step on the reversed digits
    assign rem2   = {rem_q[a], 1'b0};
    assign rem_ge = (rem2 >= {1'b0, den_q[a]});

    assign diff    = {cfg_hi_q[a][hpg_pkg::COORD_W-1], cfg_hi_q[a]}
                   - {cfg_lo_q[a][hpg_pkg::COORD_W-1], cfg_lo_q[a]};
    assign acc_add = qb_q[a] ? hpg_pkg::ACC_W'(mag_q[a]) : '0;
    assign acc_hi  = acc_q[a][hpg_pkg::ACC_W-1 -: hpg_pkg::COORD_W];
    assign sticky  = |acc_q[a][hpg_pkg::FRAC_W-1:0];

    always_ff @(posedge clk_i) begin
      unique case (state_q)
        ST_IDLE: begin
          p_q[a]    <= hpg_pkg::P_W'(sample_index_i) + 1'b1;
          rev_q[a]  <= '0;
          den_q[a]  <= hpg_pkg::DEN_W'(1);
          diff_q[a] <= diff;
        end
        ST_DIGIT: begin
          pprev_q[a] <= p_q[a];
          p_q[a]     <= quot;
          // remainder follows the reversed digits, last digit included
          if (dv_q && (pprev_q[a] != '0)) begin
            rev_q[a] <= rev_step;
            rem_q[a] <= rev_step;
            den_q[a] <= hpg_pkg::DEN_W'(den_q[a] * hpg_pkg::DEN_W'(Base));
          end else begin
            rem_q[a] <= rev_q[a];
          end
          neg_q[a] <= diff_q[a][hpg_pkg::COORD_W];
          mag_q[a] <= diff_q[a][hpg_pkg::COORD_W] ?
                      hpg_pkg::COORD_W'(-diff_q[a]) : hpg_pkg::COORD_W'(diff_q[a]);
          qb_q[a]  <= 1'b0;
          acc_q[a] <= '0;
        end
        ST_DIV: begin
          // divide bit now, accumulate the previous bit msb first
          rem_q[a] <= rem_ge ? hpg_pkg::DEN_W'(rem2 - {1'b0, den_q[a]})
                             : hpg_pkg::DEN_W'(rem2);
          qb_q[a]  <= rem_ge;
          acc_q[a] <= {acc_q[a][hpg_pkg::ACC_W-2:0], 1'b0} + acc_add;
        end
        ST_FIN: begin
          // negative span rounds the offset towards minus infinity
          coord_q[a] <= neg_q[a] ?
                        cfg_lo_q[a] + ~acc_hi + hpg_pkg::COORD_W'(!sticky) :
                        cfg_lo_q[a] + acc_hi;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FIN))
    else $error("result strobe without final step");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DIGIT) && (cnt_q == '0) && !dv_q)
    else $error("accepted word did not start the digit stage");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q[0] < den_q[0]))
    else $error("divide remainder not below base power");

endmodule
